@@ rtl/core/bkm_pkg.sv @@
// Shared widths, register indexes, mode codes and Q30 sine-table constants of the binary keying modulator.
package bkm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MODE_W     = 2;
    localparam int FREQ_W     = 24;
    localparam int AMP_W      = 8;
    localparam int OFFSET_W   = 24;
    localparam int SAMPLE_W   = 24;

    localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_WORD_ZERO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_WORD_ONE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_ZERO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_ONE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET   = 3'd5;

    localparam logic [MODE_W-1:0] MODE_ASK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FSK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PSK = 2'd2;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] HALF_Q30    = 64'd536870912;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

endpackage

@@ rtl/core/bkm_in_if.sv @@
// Input channel of the modulator: one data bit and a restart flag per sample.
interface bkm_in_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic restart;

    modport source (output valid, output data_bit, output restart, input ready);
    modport sink (input valid, input data_bit, input restart, output ready);
endinterface

@@ rtl/core/bkm_out_if.sv @@
// Output channel of the modulator: one signed carrier sample per transfer.
interface bkm_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bkm_pkg::SAMPLE_W-1:0]   sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

@@ rtl/core/bkm_cfg_if.sv @@
// Configuration write channel of the modulator: register index and write data.
interface bkm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bkm_pkg::CFG_IDX_W-1:0]     index;
    logic [bkm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/binary_keying_modulator.sv @@
// Top level of the ASK / FSK / PSK binary keying modulator with a dual phase accumulator.
//
// The input channel carries one data bit and a restart flag per output sample. A transfer
// with restart set clears both phase accumulators before its sample is formed. The output
// channel carries one signed 24-bit sample, the amplitude times a Q1.15-style sine.
// The configuration channel writes the mode, both frequency words, both amplitudes and the
// phase offset; it is always ready and should be used only while no samples are in flight.
//
// The datapath is a four-stage pipeline: phase select and accumulator update, quarter-wave
// sine ROM read, amplitude multiply, and sign with saturation into the output register.
// Each sample is registered in each stage in turn on its way to the output, and one sample per
// cycle is sustained while the receiver keeps ready high.
// When the receiver stalls, the held sample stays in the output register and the earlier
// stages keep filling, so up to three further inputs are taken before input ready drops.
// Synchronous reset clears all configuration registers to zero, both accumulators and all
// stage valid bits.
module binary_keying_modulator #(
    parameter int PHASE_BITS    = 24,
    parameter int LUT_ADDR_BITS = 10,
    parameter int SINE_BITS     = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bkm_in_if.sink    i_in,
    bkm_out_if.source o_out,
    bkm_cfg_if.sink   i_cfg
);

    localparam int QUARTER_LEN = 1 << LUT_ADDR_BITS;
    localparam int IDX_W       = LUT_ADDR_BITS + 2;
    localparam int ROM_IDX_W   = LUT_ADDR_BITS + 1;
    localparam int MAG_W       = SINE_BITS - 1;
    localparam int PROD_W      = bkm_pkg::AMP_W + MAG_W;
    localparam int EXT_W       =
        (PROD_W > bkm_pkg::SAMPLE_W ? PROD_W : bkm_pkg::SAMPLE_W) + 1;
    localparam logic [EXT_W-1:0] SAT_POS = EXT_W'((64'd1 << (bkm_pkg::SAMPLE_W - 1)) - 64'd1);
    localparam logic [EXT_W-1:0] SAT_NEG = EXT_W'(64'd1 << (bkm_pkg::SAMPLE_W - 1));

    typedef logic [MAG_W-1:0] t_rom [0:QUARTER_LEN];

    function automatic t_rom build_rom();
        t_rom               rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        scale;
        logic [63:0]        v;
        logic signed [63:0] sum;
        scale = (64'd1 << (SINE_BITS - 1)) - 64'd1;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            x    = (bkm_pkg::HALF_PI_Q30 * 64'(k)) >> LUT_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int n = 1; n <= 7; n++) begin
                term = (term * x2) >> 30;
                unique case (n)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    6:       term = term / 64'd156;
                    default: term = term / 64'd210;
                endcase
                if ((n & 1) != 0) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            if (sum > signed'(bkm_pkg::ONE_Q30)) begin
                sum = signed'(bkm_pkg::ONE_Q30);
            end
            v = (unsigned'(sum) * scale + bkm_pkg::HALF_Q30) >> 30;
            if (v > scale) begin
                v = scale;
            end
            rom[k] = v[MAG_W-1:0];
        end
        return rom;
    endfunction

    localparam t_rom QUARTER_ROM = build_rom();

    // Configuration registers.
    logic [bkm_pkg::MODE_W-1:0]   r_mode;
    logic [bkm_pkg::FREQ_W-1:0]   r_freq_word_zero;
    logic [bkm_pkg::FREQ_W-1:0]   r_freq_word_one;
    logic [bkm_pkg::AMP_W-1:0]    r_amplitude_zero;
    logic [bkm_pkg::AMP_W-1:0]    r_amplitude_one;
    logic [bkm_pkg::OFFSET_W-1:0] r_phase_offset;

    logic [PHASE_BITS-1:0] r_acc_zero;
    logic [PHASE_BITS-1:0] r_acc_one;

    logic                          r_s1_valid;
    logic [PHASE_BITS-1:0]         r_s1_phase;
    logic [bkm_pkg::AMP_W-1:0]     r_s1_amp;
    logic                          r_s2_valid;
    logic [MAG_W-1:0]              r_s2_mag;
    logic                          r_s2_neg;
    logic [bkm_pkg::AMP_W-1:0]     r_s2_amp;
    logic                          r_s3_valid;
    logic [PROD_W-1:0]             r_s3_prod;
    logic                          r_s3_neg;
    logic                          r_s4_valid;
    logic [bkm_pkg::SAMPLE_W-1:0]  r_s4_sample;

    logic                          w_adv1;
    logic                          w_adv2;
    logic                          w_adv3;
    logic                          w_adv4;
    logic                          w_in_xfer;
    logic [PHASE_BITS-1:0]         w_acc_zero;
    logic [PHASE_BITS-1:0]         w_acc_one;
    logic [PHASE_BITS-1:0]         w_fw_zero;
    logic [PHASE_BITS-1:0]         w_fw_one;
    logic [PHASE_BITS-1:0]         w_offset;
    logic [PHASE_BITS-1:0]         w_half_turn;
    logic [PHASE_BITS-1:0]         n_s1_phase;
    logic [bkm_pkg::AMP_W-1:0]     n_s1_amp;
    logic [IDX_W-1:0]              w_idx;
    logic [LUT_ADDR_BITS-1:0]      w_addr;
    logic [ROM_IDX_W-1:0]          w_rom_idx;
    logic [EXT_W-1:0]              w_mag_ext;
    logic [EXT_W-1:0]              w_neg_ext;
    logic [bkm_pkg::SAMPLE_W-1:0]  n_s4_sample;

    // A stage loads whenever it is empty or its content moves on in the same cycle.
    assign w_adv4    = !r_s4_valid || o_out.ready;
    assign w_adv3    = !r_s3_valid || w_adv4;
    assign w_adv2    = !r_s2_valid || w_adv3;
    assign w_adv1    = !r_s1_valid || w_adv2;
    assign w_in_xfer = i_in.valid && w_adv1;

    assign i_in.ready   = w_adv1;
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_s4_valid;
    assign o_out.sample = r_s4_sample;

    assign w_acc_zero  = i_in.restart ? '0 : r_acc_zero;
    assign w_acc_one   = i_in.restart ? '0 : r_acc_one;
    assign w_fw_zero   = PHASE_BITS'(r_freq_word_zero);
    assign w_fw_one    = PHASE_BITS'(r_freq_word_one);
    assign w_offset    = PHASE_BITS'(r_phase_offset);
    assign w_half_turn = PHASE_BITS'(i_in.data_bit) << (PHASE_BITS - 1);

    always_comb begin
        n_s1_amp = r_amplitude_zero;
        unique case (r_mode)
            bkm_pkg::MODE_FSK: begin
                n_s1_phase = (i_in.data_bit ? w_acc_one : w_acc_zero) + w_offset;
            end
            bkm_pkg::MODE_PSK: begin
                n_s1_phase = w_acc_zero + w_half_turn;
            end
            default: begin
                n_s1_phase = w_acc_zero + w_offset;
                if (i_in.data_bit) begin
                    n_s1_amp = r_amplitude_one;
                end
            end
        endcase
    end

    generate
        if (PHASE_BITS >= IDX_W) begin : g_idx_top
            assign w_idx = r_s1_phase[PHASE_BITS-1 -: IDX_W];
        end else begin : g_idx_pad
            assign w_idx = {r_s1_phase, {(IDX_W - PHASE_BITS){1'b0}}};
        end
    endgenerate

    assign w_addr    = w_idx[LUT_ADDR_BITS-1:0];
    assign w_rom_idx = w_idx[LUT_ADDR_BITS]
                     ? ROM_IDX_W'(QUARTER_LEN) - {1'b0, w_addr}
                     : {1'b0, w_addr};

    assign w_mag_ext = EXT_W'(r_s3_prod);
    assign w_neg_ext = '0 - w_mag_ext;

    always_comb begin
        if (r_s3_neg) begin
            if (w_mag_ext > SAT_NEG) begin
                n_s4_sample = SAT_NEG[bkm_pkg::SAMPLE_W-1:0];
            end else begin
                n_s4_sample = w_neg_ext[bkm_pkg::SAMPLE_W-1:0];
            end
        end else begin
            if (w_mag_ext > SAT_POS) begin
                n_s4_sample = SAT_POS[bkm_pkg::SAMPLE_W-1:0];
            end else begin
                n_s4_sample = w_mag_ext[bkm_pkg::SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= bkm_pkg::MODE_ASK;
            r_freq_word_zero <= '0;
            r_freq_word_one  <= '0;
            r_amplitude_zero <= '0;
            r_amplitude_one  <= '0;
            r_phase_offset   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bkm_pkg::REG_MODE:           r_mode <= i_cfg.data[bkm_pkg::MODE_W-1:0];
                bkm_pkg::REG_FREQ_WORD_ZERO: r_freq_word_zero <= i_cfg.data;
                bkm_pkg::REG_FREQ_WORD_ONE:  r_freq_word_one <= i_cfg.data;
                bkm_pkg::REG_AMPLITUDE_ZERO: begin
                    r_amplitude_zero <= i_cfg.data[bkm_pkg::AMP_W-1:0];
                end
                bkm_pkg::REG_AMPLITUDE_ONE: begin
                    r_amplitude_one <= i_cfg.data[bkm_pkg::AMP_W-1:0];
                end
                bkm_pkg::REG_PHASE_OFFSET:   r_phase_offset <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_zero <= '0;
            r_acc_one  <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_acc_zero <= w_acc_zero + w_fw_zero;
                r_acc_one  <= w_acc_one + w_fw_one;
            end
            if (w_adv1) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_adv2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_adv3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_adv4) begin
                r_s4_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_phase <= n_s1_phase;
            r_s1_amp   <= n_s1_amp;
        end
        if (w_adv2 && r_s1_valid) begin
            r_s2_mag <= QUARTER_ROM[w_rom_idx];
            r_s2_neg <= w_idx[IDX_W-1];
            r_s2_amp <= r_s1_amp;
        end
        if (w_adv3 && r_s2_valid) begin
            r_s3_prod <= PROD_W'(r_s2_amp) * PROD_W'(r_s2_mag);
            r_s3_neg  <= r_s2_neg;
        end
        if (w_adv4 && r_s3_valid) begin
            r_s4_sample <= n_s4_sample;
        end
    end

endmodule

@@ rtl/core/bkm_checker.sv @@
// Port-level checker of the binary keying modulator and its bind to the top level.
module bkm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [bkm_pkg::SAMPLE_W-1:0] i_out_sample
);

    // A stalled sample must stay offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sample))
        else $error("stalled output sample dropped or changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // A receiver that is ready never blocks the input side.
    a_ready_pass: assert property (@(posedge i_clk)
        i_out_ready |-> i_in_ready)
        else $error("input not ready while output is ready");

    // With the receiver ready throughout, a transfer reaches the output once it has passed every stage.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_out_ready) ##1 i_out_ready ##1 i_out_ready
        ##1 i_out_ready |=> i_out_valid)
        else $error("sample missing four cycles after input transfer");

endmodule

bind binary_keying_modulator bkm_checker u_bkm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample)
);
